// File: src/smtk_pkg.sv
// Shared types and constants for the score map top-k keypoint selector.
// No dependencies.
package smtk_pkg;
  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int TOP_K = 32;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int KW = $clog2(TOP_K + 1);
  localparam int POS_W = 26;

  localparam logic [2:0] REG_THRESH = 3'd0;
  localparam logic [2:0] REG_BORDER = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_KEEP   = 3'd4;
  localparam logic [2:0] REG_XSCALE = 3'd5;
  localparam logic [2:0] REG_YSCALE = 3'd6;

  typedef struct packed {
    logic [15:0] score;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
  } entry_t;

  typedef struct packed {
    logic       keep;
    logic       frame_end;
    entry_t     ent;
  } cmd_t;
endpackage

// File: src/smtk_front.sv
// Front end: raster counters and survivor classification.
// Depends on smtk_pkg.
module smtk_front (
  input  logic clk,
  input  logic rst_n,
  input  logic acc,
  input  logic [15:0] score,
  input  logic allowed,
  input  logic [15:0] thresh,
  input  logic [7:0] border,
  input  logic [10:0] map_w,
  input  logic [10:0] map_h,
  output smtk_pkg::cmd_t cmd
);
  import smtk_pkg::*;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [12:0] w, h, b2;
  logic in_x, in_y, row_end;

  always_comb begin
    w = (map_w == 11'd0) ? 13'd1 : (map_w > 11'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(map_w);
    h = (map_h == 11'd0) ? 13'd1 : (map_h > 11'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(map_h);
    b2 = {4'd0, border, 1'b0};
    in_x = (b2 < w) && (13'(col_r) >= 13'(border)) && (13'(col_r) < w - 13'(border));
    in_y = (b2 < h) && (13'(row_r) >= 13'(border)) && (13'(row_r) < h - 13'(border));
    row_end = 13'(col_r) + 13'd1 >= w;
    cmd.frame_end = row_end && (13'(row_r) + 13'd1 >= h);
    cmd.keep = (score > thresh) && allowed && in_x && in_y;
    cmd.ent = '{score: score, col: col_r, row: row_r};
    col_nxt = row_end ? '0 : col_r + 1'b1;
    row_nxt = cmd.frame_end ? '0 : row_end ? row_r + 1'b1 : row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end
endmodule

// File: src/smtk_back.sv
// Back end: sorted top-k list, insertion and emission sequencer.
// Depends on smtk_pkg.
module smtk_back (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_vld,
  input  smtk_pkg::cmd_t cmd,
  output logic cmd_rdy,
  input  logic [5:0] keep_cnt,
  input  logic [15:0] xs,
  input  logic [15:0] ys,
  output logic out_valid,
  output logic [25:0] out_x_pos,
  output logic [25:0] out_y_pos,
  output logic [15:0] out_point_score,
  output logic out_found,
  output logic out_last_of_frame
);
  import smtk_pkg::*;
  typedef enum logic [1:0] {S_RUN, S_EMIT, S_MUL} st_t;
  st_t st_r;
  entry_t ent_r [TOP_K];
  logic [KW-1:0] tot_r, idx_r, n_r;
  logic [KW-1:0] k, tot_c, p;
  logic [TOP_K-1:0] ge;
  logic [CW+15:0] xp_r;
  logic [RW+15:0] yp_r;
  logic [15:0] sc_r;
  logic lst_r;

  assign cmd_rdy = (st_r == S_RUN);
  always_comb begin
    k = (keep_cnt == 6'd0) ? KW'(1) : (7'(keep_cnt) > 7'(TOP_K)) ? KW'(TOP_K) : KW'(keep_cnt);
    tot_c = (tot_r > k) ? k : tot_r;
    for (int i = 0; i < TOP_K; i++)
      ge[i] = (KW'(i) < tot_c) && (ent_r[i].score >= cmd.ent.score);
    p = KW'($countones(ge));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_RUN;
      tot_r <= '0;
      idx_r <= '0;
      n_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (st_r)
        S_RUN: begin
          if (cmd_vld) begin
            logic [KW-1:0] t;
            t = tot_c;
            if (cmd.keep && p < k) begin
              for (int i = TOP_K - 1; i > 0; i--)
                if (KW'(i) > p && KW'(i) < k) ent_r[i] <= ent_r[i-1];
              for (int i = 0; i < TOP_K; i++)
                if (KW'(i) == p) ent_r[i] <= cmd.ent;
              if (t < k) t = t + 1'b1;
              tot_r <= t;
            end
            if (cmd.frame_end) begin
              n_r <= t;
              idx_r <= '0;
              st_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (n_r == '0) begin
            xp_r <= '0;
            yp_r <= '0;
            sc_r <= '0;
            lst_r <= 1'b1;
          end else begin
            xp_r <= {16'd0, ent_r[idx_r[$clog2(TOP_K)-1:0]].col} * {10'd0, xs};
            yp_r <= {16'd0, ent_r[idx_r[$clog2(TOP_K)-1:0]].row} * {10'd0, ys};
            sc_r <= ent_r[idx_r[$clog2(TOP_K)-1:0]].score;
            lst_r <= (idx_r + 1'b1 == n_r);
          end
          st_r <= S_EMIT;
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          out_x_pos <= POS_W'(xp_r);
          out_y_pos <= POS_W'(yp_r);
          out_point_score <= sc_r;
          out_found <= (n_r != '0);
          out_last_of_frame <= lst_r;
          idx_r <= idx_r + 1'b1;
          if (lst_r) begin
            st_r <= S_RUN;
            tot_r <= '0;
          end else begin
            st_r <= S_MUL;
          end
        end
        default: st_r <= S_RUN;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) tot_r <= KW'(TOP_K))
    else $error("kept total over depth");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r != S_EMIT) else $error("emit overlap");
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_frame) |-> tot_r == '0) else $error("list not cleared");
`endif
endmodule

// File: src/smtk_queue.sv
// Two-entry command queue between front and back ends.
// Depends on smtk_pkg.
module smtk_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  smtk_pkg::cmd_t wd,
  output logic full,
  output logic vld,
  output smtk_pkg::cmd_t rd,
  input  logic rdy
);
  import smtk_pkg::*;
  cmd_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic pop;
  assign vld = cnt_r != 2'd0;
  assign full = cnt_r == 2'd2;
  assign rd = q_r[rp_r];
  assign pop = vld && rdy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        q_r[wp_r] <= wd;
        wp_r <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(pop);
    end
  end
endmodule

// File: src/score_map_top_k_keypoint_select_core.sv
// Top level of the score map top-k keypoint selector.
// Depends on smtk_pkg, smtk_front, smtk_queue, smtk_back.
//
// Usage: drive in_score/in_allowed with start high; a pixel is taken at an
// edge where start is high and busy is low, in raster order. Registers are
// written through cfg_valid/cfg_ready with cfg_index/cfg_data while idle.
// Throughput: one pixel per cycle during a frame while busy is low; the back end
// inserts into the sorted list in its run state, with a two-entry queue
// between classification and insertion.
// After the last pixel of a frame busy stays high while results are sent:
// each result passes a position multiply state, then the output register;
// an empty frame gives one result with out_found low. Each result is shown
// for one cycle with out_valid high; the receiver cannot stall. The first
// result is driven once the last pixel has passed the queue, the insertion,
// the multiply state and the output register; busy drops after the last result.
// Reset: counters zero, list empty, registers at their defaults.
module score_map_top_k_keypoint_select_core (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [15:0] in_score,
  input  logic in_allowed,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic out_valid,
  output logic [25:0] out_x_pos,
  output logic [25:0] out_y_pos,
  output logic [15:0] out_point_score,
  output logic out_found,
  output logic out_last_of_frame
);
  import smtk_pkg::*;
  logic [15:0] thr_r, xs_r, ys_r;
  logic [7:0] bor_r;
  logic [10:0] w_r, h_r;
  logic [5:0] k_r;
  logic acc, full, qv, qr, hold_r;
  cmd_t fc, qc;

  assign cfg_ready = 1'b1;
  assign acc = start && !busy;
  assign busy = full || hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd328; bor_r <= 8'd4; w_r <= 11'd640; h_r <= 11'd480;
      k_r <= 6'd32; xs_r <= 16'd256; ys_r <= 16'd256; hold_r <= 1'b0;
    end else begin
      if (acc && fc.frame_end) hold_r <= 1'b1;
      else if (out_valid && out_last_of_frame) hold_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_THRESH: thr_r <= cfg_data;
          REG_BORDER: bor_r <= cfg_data[7:0];
          REG_WIDTH:  w_r <= cfg_data[10:0];
          REG_HEIGHT: h_r <= cfg_data[10:0];
          REG_KEEP:   k_r <= cfg_data[5:0];
          REG_XSCALE: xs_r <= cfg_data;
          REG_YSCALE: ys_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  smtk_front u_front (.clk, .rst_n, .acc, .score(in_score), .allowed(in_allowed),
    .thresh(thr_r), .border(bor_r), .map_w(w_r), .map_h(h_r), .cmd(fc));
  smtk_queue u_queue (.clk, .rst_n, .wr(acc), .wd(fc), .full, .vld(qv), .rd(qc), .rdy(qr));
  smtk_back u_back (.clk, .rst_n, .cmd_vld(qv), .cmd(qc), .cmd_rdy(qr), .keep_cnt(k_r),
    .xs(xs_r), .ys(ys_r), .out_valid, .out_x_pos, .out_y_pos, .out_point_score,
    .out_found, .out_last_of_frame);
endmodule
